@@ hdl/srsi_pkg.sv @@
// Package for the sorted relation set insert block.
// Holds sizes, function and status codes and the channel payload types. No dependencies.
package srsi_pkg;

   localparam int RelDepth   = 1024;
   localparam int UnxDepth   = 256;
   localparam int OutDepth   = 64;
   localparam int IdBits     = 16;
   localparam int RelAw      = $clog2(RelDepth);
   localparam int UnxAw      = $clog2(UnxDepth);
   localparam int OutAw      = $clog2(OutDepth);
   localparam int KeyBits    = 2 * IdBits + 2;
   localparam int OutBits    = 2 * IdBits;

   typedef enum logic [2:0] {
      FUNC_INSERT   = 3'd0,
      FUNC_RD_REL   = 3'd1,
      FUNC_RD_UNX   = 3'd2,
      FUNC_RD_OUT   = 3'd3,
      FUNC_CLEAR    = 3'd4
   } func_type;

   typedef enum logic [3:0] {
      ST_IGNORED    = 4'd0,
      ST_OUT_ADDED  = 4'd1,
      ST_OUT_PRES   = 4'd2,
      ST_INSERTED   = 4'd3,
      ST_DUP        = 4'd4,
      ST_UNX_ADDED  = 4'd5,
      ST_UNX_DUP    = 4'd6,
      ST_FULL       = 4'd7,
      ST_READ_OK    = 4'd8,
      ST_RANGE      = 4'd9,
      ST_CLEARED    = 4'd10
   } status_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] first_id;
      logic [15:0] second_id;
      logic [7:0]  first_set;
      logic [7:0]  second_set;
      logic [1:0]  relation_type;
      logic [9:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [9:0]  position;
      logic [15:0] read_low_id;
      logic [15:0] read_high_id;
      logic [1:0]  read_type;
      logic [10:0] relation_count;
      logic [8:0]  unexpected_count;
      logic [6:0]  outlet_count;
   } rsp_type;

endpackage

@@ hdl/srsi_if.sv @@
// Valid/ready channel interfaces for requests and responses.
// Depends on srsi_pkg.
interface srsi_req_if import srsi_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface srsi_rsp_if import srsi_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hdl/srsi_ram.sv @@
// Generic single port RAM with registered read.
// No dependencies.
module srsi_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   // Write or read one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

@@ hdl/sorted_relation_set_insert.sv @@
// Channel   | dir | handshake         | payload
// req       | in  | req_valid/ready   | func, ids, sets, type, entry_index
// rsp       | out | rsp_valid/ready   | status, position, read fields, counts
// One request at a time. A read passes through decode and a RAM read wait before it answers.
// An outlet insert checks the list one entry at a time (up to 64 entries), in the
// states OSCAN, BADDR and BCMP. A table insert runs a binary search over BADDR and BCMP,
// then moves each entry above the slot through SHRD and SHWR.
// One single-port RAM per table; the two sorted tables share one port and one key compare.
// Reset (synchronous, active high) empties the tables; the response holds
// under rsp_ready low, and no new request is taken until it leaves.
// Depends on srsi_pkg, srsi_if and srsi_ram.
module sorted_relation_set_insert import srsi_pkg::*; (
   input logic         clock,
   input logic         reset,
   srsi_req_if.sink    req,
   srsi_rsp_if.source  rsp
);
   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_DEC   = 9'b000000010,
      S_RWAIT = 9'b000000100,
      S_OSCAN = 9'b000001000,
      S_BADDR = 9'b000010000,
      S_BCMP  = 9'b000100000,
      S_SHRD  = 9'b001000000,
      S_SHWR  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff;
   rsp_type   rsp_ff, rsp_in;
   logic [RelAw:0]   rfill_ff, rfill_in;
   logic [UnxAw:0]   ufill_ff, ufill_in;
   logic [OutAw:0]   ofill_ff, ofill_in;
   logic [RelAw:0]   lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, ptr_ff, ptr_in;
   logic             unx_ff, unx_in;
   logic [KeyBits-1:0] key_ff, key_in;
   logic [IdBits-1:0]  basin_ff, basin_in, limit_ff, limit_in;

   logic               rel_we, unx_we, out_we;
   logic [RelAw-1:0]   rel_addr;
   logic [UnxAw-1:0]   unx_addr;
   logic [OutAw-1:0]   out_addr;
   logic [KeyBits-1:0] rel_wd, unx_wd, rel_rd, unx_rd, tab_rd, tab_wd;
   logic [OutBits-1:0] out_rd;
   logic [RelAw-1:0]   tab_addr;
   logic               tab_we;

   srsi_ram #(.Width(KeyBits), .Depth(RelDepth)) u_rel (
      .clock(clock), .wr_en(rel_we), .addr(rel_addr), .wr_data(rel_wd), .rd_data(rel_rd));
   srsi_ram #(.Width(KeyBits), .Depth(UnxDepth)) u_unx (
      .clock(clock), .wr_en(unx_we), .addr(unx_addr), .wr_data(unx_wd), .rd_data(unx_rd));
   srsi_ram #(.Width(OutBits), .Depth(OutDepth)) u_out (
      .clock(clock), .wr_en(out_we), .addr(out_addr),
      .wr_data({basin_ff, limit_ff}), .rd_data(out_rd));

   // Steer the shared table port
   assign rel_we   = tab_we && !unx_ff;
   assign unx_we   = tab_we && unx_ff;
   assign rel_addr = tab_addr;
   assign unx_addr = tab_addr[UnxAw-1:0];
   assign rel_wd   = tab_wd;
   assign unx_wd   = tab_wd;
   assign tab_rd   = unx_ff ? unx_rd : rel_rd;

   logic [RelAw:0] fill_sel;
   logic [RelAw:0] depth_sel;
   assign fill_sel  = unx_ff ? (RelAw+1)'(ufill_ff) : rfill_ff;
   assign depth_sel = unx_ff ? (RelAw+1)'(UnxDepth) : (RelAw+1)'(RelDepth);

   // Shared key compare
   logic key_eq, key_lt;
   assign key_eq = (tab_rd == key_ff);
   assign key_lt = (key_ff < tab_rd);

   logic [IdBits-1:0] aid, bid;
   logic [7:0]        aset, bset;
   logic              swap;
   assign swap = req_ff.second_id < req_ff.first_id;
   assign aid  = swap ? req_ff.second_id : req_ff.first_id;
   assign bid  = swap ? req_ff.first_id : req_ff.second_id;
   assign aset = swap ? req_ff.second_set : req_ff.first_set;
   assign bset = swap ? req_ff.first_set : req_ff.second_set;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_DONE);
   assign rsp.data  = rsp_ff;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      rsp_in   = rsp_ff;
      rfill_in = rfill_ff;
      ufill_in = ufill_ff;
      ofill_in = ofill_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      ptr_in   = ptr_ff;
      unx_in   = unx_ff;
      key_in   = key_ff;
      basin_in = basin_ff;
      limit_in = limit_ff;
      tab_we   = 1'b0;
      tab_addr = mid_ff[RelAw-1:0];
      tab_wd   = key_ff;
      out_we   = 1'b0;
      out_addr = ptr_ff[OutAw-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            rsp_in = '0;
            ptr_in = '0;
            tab_addr = req_ff.entry_index[RelAw-1:0];
            out_addr = req_ff.entry_index[OutAw-1:0];
            basin_in = (aset == 8'd0) ? aid : bid;
            limit_in = (aset == 8'd0) ? bid : aid;
            key_in   = {aid, bid, req_ff.relation_type};
            unx_in   = (req_ff.func == FUNC_RD_UNX) ||
                       (req_ff.func == FUNC_INSERT && req_ff.relation_type != 2'd0);
            lo_in    = '0;
            state_in = S_DONE;
            unique case (req_ff.func)
               FUNC_INSERT: begin
                  rsp_in.status = ST_IGNORED;
                  if (aset != bset && req_ff.relation_type == 2'd0) begin
                     state_in = S_OSCAN;
                  end else if (aid != bid && aset == 8'd0 && bset == 8'd0) begin
                     hi_in    = (req_ff.relation_type != 2'd0) ? (RelAw+1)'(ufill_ff)
                                                              : rfill_ff;
                     state_in = S_BADDR;
                  end
               end
               FUNC_RD_REL, FUNC_RD_UNX, FUNC_RD_OUT: begin
                  state_in = S_RWAIT;
               end
               FUNC_CLEAR: begin
                  rfill_in = '0;
                  ufill_in = '0;
                  ofill_in = '0;
                  rsp_in.status = ST_CLEARED;
               end
               default: rsp_in.status = ST_IGNORED;
            endcase
         end
         S_RWAIT: begin
            state_in = S_DONE;
            rsp_in.status = ST_RANGE;
            if (req_ff.func == FUNC_RD_OUT) begin
               if ({1'b0, req_ff.entry_index} < 11'(ofill_ff)) begin
                  rsp_in.status       = ST_READ_OK;
                  rsp_in.position     = req_ff.entry_index;
                  rsp_in.read_low_id  = out_rd[OutBits-1:IdBits];
                  rsp_in.read_high_id = out_rd[IdBits-1:0];
               end
            end else if ({1'b0, req_ff.entry_index} < 11'(fill_sel)) begin
               rsp_in.status       = ST_READ_OK;
               rsp_in.position     = req_ff.entry_index;
               rsp_in.read_low_id  = tab_rd[KeyBits-1:IdBits+2];
               rsp_in.read_high_id = tab_rd[IdBits+1:2];
               rsp_in.read_type    = tab_rd[1:0];
            end
         end
         S_OSCAN: begin
            // The previous state presented address ptr_ff-1; its data is valid here
            out_addr = ptr_ff[OutAw-1:0] + OutAw'(1);
            if (ptr_ff >= ofill_ff) begin
               state_in = S_DONE;
               if (ofill_ff >= (OutAw+1)'(OutDepth)) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  out_we   = 1'b1;
                  out_addr = ofill_ff[OutAw-1:0];
                  rsp_in.status   = ST_OUT_ADDED;
                  rsp_in.position = 10'(ofill_ff);
                  ofill_in = ofill_ff + 1'b1;
               end
            end else begin
               state_in = S_BADDR;
               // reuse BADDR as a read wait for the outlet list
               lo_in = '1;
            end
         end
         S_BADDR: begin
            if (lo_ff == '1) begin
               // outlet compare
               out_addr = ptr_ff[OutAw-1:0];
               lo_in = '0;
               mid_in = '1;
               state_in = S_BCMP;
            end else if (lo_ff >= hi_ff) begin
               if (fill_sel >= depth_sel) begin
                  rsp_in.status = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  ptr_in   = fill_sel;
                  state_in = S_SHRD;
               end
            end else begin
               mid_in   = lo_ff + ((hi_ff - lo_ff) >> 1);
               tab_addr = mid_in[RelAw-1:0];
               state_in = S_BCMP;
            end
         end
         S_BCMP: begin
            if (mid_ff == '1) begin
               // outlet entry compare
               mid_in = '0;
               if (out_rd[OutBits-1:IdBits] == basin_ff) begin
                  rsp_in.status   = ST_OUT_PRES;
                  rsp_in.position = 10'(ptr_ff);
                  state_in = S_DONE;
               end else begin
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = S_OSCAN;
               end
            end else if (key_eq) begin
               rsp_in.status   = unx_ff ? ST_UNX_DUP : ST_DUP;
               rsp_in.position = 10'(mid_ff);
               state_in = S_DONE;
            end else begin
               if (key_lt) hi_in = mid_ff;
               else        lo_in = mid_ff + 1'b1;
               state_in = S_BADDR;
            end
         end
         S_SHRD: begin
            if (ptr_ff == lo_ff) begin
               tab_we   = 1'b1;
               tab_addr = lo_ff[RelAw-1:0];
               tab_wd   = key_ff;
               rsp_in.status   = unx_ff ? ST_UNX_ADDED : ST_INSERTED;
               rsp_in.position = 10'(lo_ff);
               if (unx_ff) ufill_in = ufill_ff + 1'b1;
               else        rfill_in = rfill_ff + 1'b1;
               state_in = S_DONE;
            end else begin
               tab_addr = ptr_in[RelAw-1:0] - RelAw'(1);
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            tab_we   = 1'b1;
            tab_addr = ptr_ff[RelAw-1:0];
            tab_wd   = tab_rd;
            ptr_in   = ptr_ff - 1'b1;
            state_in = S_SHRD;
         end
         S_DONE: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // Track the fill counts in the response
      rsp_in.relation_count   = 11'(rfill_in);
      rsp_in.unexpected_count = 9'(ufill_in);
      rsp_in.outlet_count     = 7'(ofill_in);
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rfill_ff <= '0;
         ufill_ff <= '0;
         ofill_ff <= '0;
      end else begin
         state_ff <= state_in;
         rfill_ff <= rfill_in;
         ufill_ff <= ufill_in;
         ofill_ff <= ofill_in;
      end
   end

   // Advance working registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         req_ff <= req.data;
      end
      rsp_ff   <= rsp_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      ptr_ff   <= ptr_in;
      unx_ff   <= unx_in;
      key_ff   <= key_in;
      basin_ff <= basin_in;
      limit_ff <= limit_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rfill_ff <= (RelAw+1)'(RelDepth))
      else $error("relation fill past depth");
   assert property (@(posedge clock) disable iff (reset)
      ufill_ff <= (UnxAw+1)'(UnxDepth))
      else $error("unexpected fill past depth");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp.ready) |=> $stable(rsp_ff))
      else $error("response changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({req.ready, rsp.valid}))
      else $error("ready while response pending");
endmodule
